// ----- design/lhp_pkg.sv -----
// Shared types, constants and helpers for the latency histogram block.
package lhp_pkg;

   localparam int STAMP_W    = 32;
   localparam int LEN_W      = 16;
   localparam int PERMILLE_W = 10;
   localparam int PCT_W      = 11;
   localparam int COUNT_W    = 32;
   localparam int SCALED_W   = COUNT_W + PERMILLE_W;

   localparam logic [LEN_W-1:0]   MIN_FRAME_BYTES = 16'd47;
   localparam int                 PERMILLE_SCALE  = 1000;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

   // queue depth must stay a power of two: pointers wrap by overflow
   localparam int QPTR_W      = 2;
   localparam int QUEUE_DEPTH = 1 << QPTR_W;

   typedef enum logic [1:0] {
      KIND_TAKE,
      KIND_SKIP,
      KIND_QUERY
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [STAMP_W-1:0]     latency;
      logic [PERMILLE_W-1:0]  permille;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      return (value == COUNT_MAX) ? value : value + 1'b1;
   endfunction

endpackage

// ----- design/lhp_front.sv -----
// Front end: accepts request beats, holds the enable register, classifies items.
module lhp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic                              csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [lhp_pkg::LEN_W-1:0]         req_frame_length,
   input  logic [lhp_pkg::STAMP_W-1:0]       req_first_stamp,
   input  logic [lhp_pkg::STAMP_W-1:0]       req_second_stamp,
   input  logic [lhp_pkg::PERMILLE_W-1:0]    req_permille,
   input  lhp_pkg::back_status_type          back_status,
   input  lhp_pkg::queue_status_type         queue_status,
   output logic                              push_valid,
   output lhp_pkg::entry_type                push_entry
);

   logic                          enable_ff;
   logic                          enable_in;
   logic [lhp_pkg::STAMP_W-1:0]   latency;

   assign enable_in = csr_write_en ? csr_write_data : enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // hold off new beats while the queue is full or the histogram is being swept clean
   assign req_ready  = !queue_status.full && !back_status.clearing;
   assign push_valid = req_valid && req_ready;

   always_comb begin
      latency             = req_second_stamp - req_first_stamp;
      push_entry.permille = req_permille;
      priority if (req_mode) begin
         push_entry.kind    = lhp_pkg::KIND_QUERY;
         push_entry.latency = '0;
      end else if (enable_ff && (req_frame_length >= lhp_pkg::MIN_FRAME_BYTES)) begin
         push_entry.kind    = lhp_pkg::KIND_TAKE;
         push_entry.latency = latency;
      end else begin
         push_entry.kind    = lhp_pkg::KIND_SKIP;
         push_entry.latency = latency;
      end
   end

endmodule

// ----- design/lhp_queue.sv -----
// Small FIFO of classified items between the front end and the histogram engine.
module lhp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  lhp_pkg::entry_type           push_entry,
   input  logic                         pop,
   output lhp_pkg::entry_type           head,
   output lhp_pkg::queue_status_type    status
);

   lhp_pkg::entry_type                  slots_ff [lhp_pkg::QUEUE_DEPTH];
   logic [lhp_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [lhp_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [lhp_pkg::QPTR_W:0]            fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (lhp_pkg::QPTR_W+1)'(push_valid) - (lhp_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == (lhp_pkg::QPTR_W+1)'(lhp_pkg::QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);

endmodule

// ----- design/lhp_back.sv -----
// Histogram engine: bin memory, statistics, percentile walk and response register.
module lhp_back #(
   parameter int NUM_BINS  = 1024,
   parameter int BIN_WIDTH = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lhp_pkg::entry_type                head,
   input  lhp_pkg::queue_status_type         queue_status,
   output logic                              pop,
   output lhp_pkg::back_status_type          back_status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_recorded,
   output logic [lhp_pkg::STAMP_W-1:0]       rsp_latency,
   output logic [lhp_pkg::PCT_W-1:0]         rsp_pct_value,
   output logic                              rsp_pct_overflow,
   output logic [lhp_pkg::COUNT_W-1:0]       rsp_sample_count,
   output logic [lhp_pkg::STAMP_W-1:0]       rsp_min_latency,
   output logic [lhp_pkg::STAMP_W-1:0]       rsp_max_latency,
   output logic [lhp_pkg::COUNT_W-1:0]       rsp_overflow_samples
);

   localparam int IDX_W = $clog2(NUM_BINS);
   localparam longint unsigned SPAN = longint'(NUM_BINS) * longint'(BIN_WIDTH);
   localparam int LAT_W    = $clog2(SPAN);
   localparam int RECIP_SH = LAT_W + $clog2(BIN_WIDTH);
   localparam int RECIP_W  = LAT_W + 1;
   localparam int PROD_W   = LAT_W + RECIP_W;
   localparam longint unsigned RECIP =
      ((longint'(1) << RECIP_SH) + longint'(BIN_WIDTH) - 1) / longint'(BIN_WIDTH);
   localparam int ACC_W  = lhp_pkg::SCALED_W + IDX_W;
   localparam int EDGE_W = lhp_pkg::PCT_W + IDX_W;

   localparam logic [lhp_pkg::STAMP_W-1:0] SPAN_LAT  = lhp_pkg::STAMP_W'(SPAN);
   localparam logic [lhp_pkg::PCT_W-1:0]   OVER_EDGE = lhp_pkg::PCT_W'(SPAN);
   localparam logic [IDX_W-1:0]            LAST_IDX  = IDX_W'(NUM_BINS - 1);

   localparam int CW = lhp_pkg::COUNT_W;
   localparam int SW = lhp_pkg::STAMP_W;
   localparam int KW = lhp_pkg::SCALED_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RECORD,
      ST_QPREP,
      ST_QWALK,
      ST_EMIT
   } state_type;

   // bin memory
   logic [CW-1:0]    bin_mem [NUM_BINS];
   logic [CW-1:0]    rd_data_ff;
   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [CW-1:0]    wr_data;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;
   logic [SW-1:0]    cur_lat_ff, cur_lat_in;
   logic             cur_in_range_ff, cur_in_range_in;
   logic [IDX_W-1:0] cur_bin_ff, cur_bin_in;
   logic [KW-1:0]    prod_ff, prod_in;
   logic [KW-1:0]    target_ff, target_in;
   logic [IDX_W-1:0] walk_addr_ff, walk_addr_in;
   logic             issue_on_ff, issue_on_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0] s1_idx_ff, s1_idx_in;
   logic             s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0] s2_idx_ff, s2_idx_in;
   logic [KW-1:0]    scaled_ff, scaled_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [lhp_pkg::PCT_W-1:0] res_pct_ff, res_pct_in;
   logic             res_over_ff, res_over_in;
   logic [CW-1:0]    total_ff, total_in;
   logic [SW-1:0]    least_ff, least_in;
   logic [SW-1:0]    most_ff, most_in;
   logic [CW-1:0]    beyond_ff, beyond_in;

   logic             out_valid_ff, out_valid_in;
   logic             out_recorded_ff, out_recorded_in;
   logic [SW-1:0]    out_latency_ff, out_latency_in;
   logic [lhp_pkg::PCT_W-1:0] out_pct_ff, out_pct_in;
   logic             out_over_ff, out_over_in;

   logic             slot_free;
   logic             load;
   logic             load_recorded;
   logic [SW-1:0]    load_latency;
   logic [lhp_pkg::PCT_W-1:0] load_pct;
   logic             load_over;
   logic             head_in_range;
   logic [PROD_W-1:0] recip_prod;
   logic [IDX_W-1:0] head_bin;
   logic [ACC_W-1:0] acc_sum;
   logic             walk_hit;
   logic [EDGE_W-1:0] bin_edge;

   assign slot_free = !out_valid_ff || rsp_ready;

   // bin index by reciprocal multiply; exact for every latency below SPAN
   assign head_in_range = (head.latency < SPAN_LAT);
   assign recip_prod    = PROD_W'(head.latency[LAT_W-1:0]) * PROD_W'(RECIP);
   assign head_bin      = recip_prod[RECIP_SH +: IDX_W];

   // running count is kept scaled by 1000 so the rank needs no division
   assign acc_sum  = acc_ff + ACC_W'(scaled_ff);
   assign walk_hit = (acc_sum >= ACC_W'(target_ff));
   assign bin_edge = EDGE_W'(s2_idx_ff) * EDGE_W'(BIN_WIDTH);

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      cur_lat_in      = cur_lat_ff;
      cur_in_range_in = cur_in_range_ff;
      cur_bin_in      = cur_bin_ff;
      prod_in         = prod_ff;
      target_in       = target_ff;
      walk_addr_in    = walk_addr_ff;
      issue_on_in     = issue_on_ff;
      s1_valid_in     = s1_valid_ff;
      s1_idx_in       = s1_idx_ff;
      s2_valid_in     = s2_valid_ff;
      s2_idx_in       = s2_idx_ff;
      scaled_in       = scaled_ff;
      acc_in          = acc_ff;
      res_pct_in      = res_pct_ff;
      res_over_in     = res_over_ff;
      total_in        = total_ff;
      least_in        = least_ff;
      most_in         = most_ff;
      beyond_in       = beyond_ff;
      rd_en           = 1'b0;
      rd_addr         = walk_addr_ff;
      wr_en           = 1'b0;
      wr_addr         = clr_addr_ff;
      wr_data         = '0;
      pop             = 1'b0;
      load            = 1'b0;
      load_recorded   = 1'b0;
      load_latency    = '0;
      load_pct        = '0;
      load_over       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_status.empty) begin
               unique case (head.kind)
                  lhp_pkg::KIND_TAKE: begin
                     pop             = 1'b1;
                     cur_lat_in      = head.latency;
                     cur_in_range_in = head_in_range;
                     cur_bin_in      = head_bin;
                     rd_en           = head_in_range;
                     rd_addr         = head_bin;
                     state_in        = ST_RECORD;
                  end
                  lhp_pkg::KIND_SKIP: begin
                     if (slot_free) begin
                        pop          = 1'b1;
                        load         = 1'b1;
                        load_latency = head.latency;
                     end
                  end
                  lhp_pkg::KIND_QUERY: begin
                     if (total_ff == '0) begin
                        // empty histogram answers at once
                        if (slot_free) begin
                           pop  = 1'b1;
                           load = 1'b1;
                        end
                     end else begin
                        pop      = 1'b1;
                        prod_in  = KW'(total_ff) * KW'(head.permille);
                        state_in = ST_QPREP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RECORD: begin
            // hold the update until the response register can take the beat
            if (slot_free) begin
               if (cur_in_range_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = cur_bin_ff;
                  wr_data = lhp_pkg::sat_inc(rd_data_ff);
               end else begin
                  beyond_in = lhp_pkg::sat_inc(beyond_ff);
               end
               total_in      = lhp_pkg::sat_inc(total_ff);
               least_in      = (cur_lat_ff < least_ff) ? cur_lat_ff : least_ff;
               most_in       = (cur_lat_ff > most_ff) ? cur_lat_ff : most_ff;
               load          = 1'b1;
               load_recorded = 1'b1;
               load_latency  = cur_lat_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_QPREP: begin
            target_in    = (prod_ff == '0) ? KW'(1) : prod_ff;
            walk_addr_in = '0;
            issue_on_in  = 1'b1;
            s1_valid_in  = 1'b0;
            s2_valid_in  = 1'b0;
            acc_in       = '0;
            state_in     = ST_QWALK;
         end
         ST_QWALK: begin
            // read, scale, accumulate: one bin enters each cycle
            rd_en = issue_on_ff;
            if (issue_on_ff) begin
               walk_addr_in = walk_addr_ff + 1'b1;
               if (walk_addr_ff == LAST_IDX) begin
                  issue_on_in = 1'b0;
               end
            end
            s1_valid_in = issue_on_ff;
            s1_idx_in   = walk_addr_ff;
            s2_valid_in = s1_valid_ff;
            s2_idx_in   = s1_idx_ff;
            scaled_in   = KW'(rd_data_ff) * KW'(lhp_pkg::PERMILLE_SCALE);
            if (s2_valid_ff) begin
               acc_in = acc_sum;
               priority if (walk_hit) begin
                  res_pct_in  = bin_edge[lhp_pkg::PCT_W-1:0];
                  res_over_in = 1'b0;
                  issue_on_in = 1'b0;
                  state_in    = ST_EMIT;
               end else if (s2_idx_ff == LAST_IDX) begin
                  res_pct_in  = OVER_EDGE;
                  res_over_in = 1'b1;
                  issue_on_in = 1'b0;
                  state_in    = ST_EMIT;
               end else begin
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load      = 1'b1;
               load_pct  = res_pct_ff;
               load_over = res_over_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in    = load ? 1'b1 : (out_valid_ff && !rsp_ready);
      out_recorded_in = load ? load_recorded : out_recorded_ff;
      out_latency_in  = load ? load_latency : out_latency_ff;
      out_pct_in      = load ? load_pct : out_pct_ff;
      out_over_in     = load ? load_over : out_over_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         issue_on_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         total_ff     <= '0;
         least_ff     <= '1;
         most_ff      <= '0;
         beyond_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         issue_on_ff  <= issue_on_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         total_ff     <= total_in;
         least_ff     <= least_in;
         most_ff      <= most_in;
         beyond_ff    <= beyond_in;
         out_valid_ff <= out_valid_in;
      end
      cur_lat_ff      <= cur_lat_in;
      cur_in_range_ff <= cur_in_range_in;
      cur_bin_ff      <= cur_bin_in;
      prod_ff         <= prod_in;
      target_ff       <= target_in;
      walk_addr_ff    <= walk_addr_in;
      s1_idx_ff       <= s1_idx_in;
      s2_idx_ff       <= s2_idx_in;
      scaled_ff       <= scaled_in;
      acc_ff          <= acc_in;
      res_pct_ff      <= res_pct_in;
      res_over_ff     <= res_over_in;
      out_recorded_ff <= out_recorded_in;
      out_latency_ff  <= out_latency_in;
      out_pct_ff      <= out_pct_in;
      out_over_ff     <= out_over_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bin_mem[rd_addr];
      end
   end

   assign back_status.clearing = (state_ff == ST_CLEAR);

   // statistics change only when a response is loaded, so they stand as its fields
   assign rsp_valid            = out_valid_ff;
   assign rsp_recorded         = out_recorded_ff;
   assign rsp_latency          = out_latency_ff;
   assign rsp_pct_value        = out_pct_ff;
   assign rsp_pct_overflow     = out_over_ff;
   assign rsp_sample_count     = total_ff;
   assign rsp_min_latency      = least_ff;
   assign rsp_max_latency      = most_ff;
   assign rsp_overflow_samples = beyond_ff;

endmodule

// ----- design/latency_histogram_percentile_top.sv -----
// Latency histogram with percentile query: top level.
//
// Request channel (req_*): mode 0 carries a frame's length and two timestamps;
// when enabled and the frame is 47 bytes or longer, the wrapped stamp difference
// is binned. Mode 1 asks for the lower bin edge at a permille rank.
// Response channel (rsp_*): exactly one beat per request, in order, carrying the
// running count, min, max and overflow-bin totals as they stand after the item.
// csr_write_en / csr_write_data set the enable bit; write it only while idle.
// Order: a record beat passes the queue, a bin read, then the update and response
// load; the engine ends each item before it pops the next. A recorded sample is a
// bin read, then an increment and write on the single-port bin memory; a query
// walks the bins from index 0 until the rank is met, at most all NUM_BINS.
// Reset: a clearing pass writes zero to all NUM_BINS bins, one per cycle, and
// req_ready stays low until the pass is done.
// Stall: the response register holds its beat until rsp_ready; the engine then
// waits while up to four requests queue up, after which req_ready drops.
module latency_histogram_percentile_top #(
   parameter int NUM_BINS  = 1024,
   parameter int BIN_WIDTH = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic                              csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [lhp_pkg::LEN_W-1:0]         req_frame_length,
   input  logic [lhp_pkg::STAMP_W-1:0]       req_first_stamp,
   input  logic [lhp_pkg::STAMP_W-1:0]       req_second_stamp,
   input  logic [lhp_pkg::PERMILLE_W-1:0]    req_permille,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_recorded,
   output logic [lhp_pkg::STAMP_W-1:0]       rsp_latency,
   output logic [lhp_pkg::PCT_W-1:0]         rsp_pct_value,
   output logic                              rsp_pct_overflow,
   output logic [lhp_pkg::COUNT_W-1:0]       rsp_sample_count,
   output logic [lhp_pkg::STAMP_W-1:0]       rsp_min_latency,
   output logic [lhp_pkg::STAMP_W-1:0]       rsp_max_latency,
   output logic [lhp_pkg::COUNT_W-1:0]       rsp_overflow_samples
);

   logic                          push_valid;
   lhp_pkg::entry_type            push_entry;
   logic                          pop;
   lhp_pkg::entry_type            head;
   lhp_pkg::queue_status_type     queue_status;
   lhp_pkg::back_status_type      back_status;

   lhp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_frame_length (req_frame_length),
      .req_first_stamp  (req_first_stamp),
      .req_second_stamp (req_second_stamp),
      .req_permille     (req_permille),
      .back_status      (back_status),
      .queue_status     (queue_status),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   lhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   lhp_back #(
      .NUM_BINS  (NUM_BINS),
      .BIN_WIDTH (BIN_WIDTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .queue_status         (queue_status),
      .pop                  (pop),
      .back_status          (back_status),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_recorded         (rsp_recorded),
      .rsp_latency          (rsp_latency),
      .rsp_pct_value        (rsp_pct_value),
      .rsp_pct_overflow     (rsp_pct_overflow),
      .rsp_sample_count     (rsp_sample_count),
      .rsp_min_latency      (rsp_min_latency),
      .rsp_max_latency      (rsp_max_latency),
      .rsp_overflow_samples (rsp_overflow_samples)
   );

   a_no_accept_while_clearing : assert property (
      @(posedge clock) disable iff (reset) back_status.clearing |-> !req_ready
   ) else $error("request beat accepted during clearing pass");

   a_no_push_when_full : assert property (
      @(posedge clock) disable iff (reset) push_valid |-> !queue_status.full
   ) else $error("queue written while full");

   a_no_pop_when_empty : assert property (
      @(posedge clock) disable iff (reset) pop |-> !queue_status.empty
   ) else $error("queue read while empty");

   a_empty_stats : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_sample_count == '0)) |->
         ((rsp_min_latency == '1) && (rsp_max_latency == '0))
   ) else $error("min/max not at reset values with no samples");

   a_recorded_within_bounds : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_recorded) |->
         ((rsp_min_latency <= rsp_latency) && (rsp_max_latency >= rsp_latency) &&
          (rsp_sample_count != '0) && !rsp_pct_overflow)
   ) else $error("recorded sample outside min/max or count empty");

endmodule
